@@ rtl/srs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the systematic particle resampler.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int PARTICLES  = 64;
    localparam int WEIGHT_W   = 16;
    localparam int OFFSET_W   = 10;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int SUM_W      = 23;
    localparam int ONE_Q16    = 65536;
    localparam int BANK_DEPTH = 1 << INDEX_W;
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int RAM_ADDR_W = INDEX_W + 1;
    localparam int STEP_Q     = ONE_Q16 / PARTICLES;
    localparam int STEP_R     = ONE_Q16 % PARTICLES;
    localparam int FRAC_W     = $clog2(PARTICLES);

    typedef struct packed {
        logic                bank;
        logic [COUNT_W-1:0]  count;
        logic [OFFSET_W-1:0] offset;
    } walk_cmd_t;

    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
        logic [WEIGHT_W-1:0]   data;
    } ram_wr_t;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_FIRST,
        WALK_CHECK,
        WALK_ADD
    } walk_state_t;

endpackage : srs_pkg
`default_nettype wire

@@ rtl/srs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srs_ram
// Generic simple dual-port ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module srs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : srs_ram
`default_nettype wire

@@ rtl/srs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srs_front
// Load side: stores each accepted weight, up to PARTICLES per batch, into the
// current bank and, on the last request, hands a walk command to the queue
// and flips the bank.
module srs_front
    import srs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [OFFSET_W-1:0] offset,
    input  wire logic                is_last,
    input  wire logic                q_full,
    output logic                     push,
    output walk_cmd_t                push_cmd,
    output ram_wr_t                  ram_wr
);

    logic               bank_reg;
    logic               bank_next;
    logic [COUNT_W-1:0] load_count_reg;
    logic [COUNT_W-1:0] load_count_next;
    logic [COUNT_W-1:0] count_stored;
    logic               accept;
    logic               has_room;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign has_room = load_count_reg < COUNT_W'(PARTICLES);

    always_comb
    begin
        ram_wr.en   = accept && has_room;
        ram_wr.addr = {bank_reg, load_count_reg[INDEX_W-1:0]};
        ram_wr.data = weight;

        count_stored = has_room ? load_count_reg + COUNT_W'(1) : load_count_reg;

        push            = accept && is_last;
        push_cmd.bank   = bank_reg;
        push_cmd.count  = count_stored;
        push_cmd.offset = offset;

        load_count_next = load_count_reg;
        bank_next       = bank_reg;
        if (accept)
        begin
            if (is_last)
            begin
                load_count_next = '0;
                bank_next       = !bank_reg;
            end
            else
            begin
                load_count_next = count_stored;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg       <= 1'b0;
            load_count_reg <= '0;
        end
        else
        begin
            bank_reg       <= bank_next;
            load_count_reg <= load_count_next;
        end
    end

endmodule : srs_front
`default_nettype wire

@@ rtl/srs_cmdq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srs_cmdq
// One-entry command queue between the load side and the walk engine.
// ----------------------------------------------------------------------------
module srs_cmdq
    import srs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire walk_cmd_t push_cmd,
    input  wire logic      pop,
    output logic           full,
    output walk_cmd_t      head
);

    logic      full_reg;
    logic      full_next;
    walk_cmd_t cmd_reg;

    always_comb
    begin
        full_next = full_reg;
        if (push)
        begin
            full_next = 1'b1;
        end
        else if (pop)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg <= push_cmd;
        end
    end

    assign full = full_reg;
    assign head = cmd_reg;

endmodule : srs_cmdq
`default_nettype wire

@@ rtl/srs_walk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srs_walk
// Walk engine: steps the running weight sum against the slot thresholds and
// emits one source index per slot through an output register.
// ----------------------------------------------------------------------------
module srs_walk
    import srs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_full,
    input  wire walk_cmd_t             q_head,
    output logic                       pop,
    output logic                       rd_en,
    output logic      [RAM_ADDR_W-1:0] rd_addr,
    input  wire logic [WEIGHT_W-1:0]   rd_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [INDEX_W-1:0]    source_index,
    output logic                       last_slot
);

    walk_state_t         state_reg;
    walk_state_t         state_next;
    logic                bank_reg;
    logic                bank_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [INDEX_W-1:0]  idx_reg;
    logic [INDEX_W-1:0]  idx_next;
    logic [INDEX_W-1:0]  slot_reg;
    logic [INDEX_W-1:0]  slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    thr_reg;
    logic [SUM_W-1:0]    thr_next;
    logic [FRAC_W-1:0]   frac_reg;
    logic [FRAC_W-1:0]   frac_next;
    logic [FRAC_W:0]     frac_sum;
    logic                frac_carry;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_last_reg;
    logic                slot_free;
    logic                advance;
    logic                emit;
    logic                final_slot;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign final_slot = slot_reg == INDEX_W'(PARTICLES - 1);
    assign advance    = (thr_reg > sum_reg)
                        && ({1'b0, idx_reg} + COUNT_W'(1) < count_reg);
    assign frac_sum   = {1'b0, frac_reg} + (FRAC_W + 1)'(STEP_R);
    assign frac_carry = frac_sum >= (FRAC_W + 1)'(PARTICLES);

    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        sum_next    = sum_reg;
        thr_next    = thr_reg;
        frac_next   = frac_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {bank_reg, idx_reg + INDEX_W'(1)};
        emit        = 1'b0;

        unique case (state_reg)
            WALK_IDLE:
            begin
                if (q_full)
                begin
                    pop         = 1'b1;
                    rd_en       = 1'b1;
                    rd_addr     = {q_head.bank, INDEX_W'(0)};
                    bank_next   = q_head.bank;
                    count_next  = q_head.count;
                    idx_next    = '0;
                    slot_next   = '0;
                    frac_next   = '0;
                    thr_next    = SUM_W'(q_head.offset);
                    state_next  = WALK_FIRST;
                end
            end
            WALK_FIRST:
            begin
                sum_next   = SUM_W'(rd_data);
                state_next = WALK_CHECK;
            end
            WALK_CHECK:
            begin
                if (advance)
                begin
                    rd_en      = 1'b1;
                    state_next = WALK_ADD;
                end
                else if (slot_free)
                begin
                    emit = 1'b1;
                    if (final_slot)
                    begin
                        state_next = WALK_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + INDEX_W'(1);
                        frac_next = frac_carry
                                    ? FRAC_W'(frac_sum - (FRAC_W + 1)'(PARTICLES))
                                    : frac_sum[FRAC_W-1:0];
                        thr_next  = thr_reg + SUM_W'(STEP_Q) + SUM_W'(frac_carry);
                    end
                end
            end
            WALK_ADD:
            begin
                sum_next   = sum_reg + SUM_W'(rd_data);
                idx_next   = idx_reg + INDEX_W'(1);
                state_next = WALK_CHECK;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg   <= bank_next;
        count_reg  <= count_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        sum_reg    <= sum_next;
        thr_reg    <= thr_next;
        frac_reg   <= frac_next;
        if (emit)
        begin
            out_index_reg <= idx_reg;
            out_last_reg  <= final_slot;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = out_index_reg;
    assign last_slot    = out_last_reg;

endmodule : srs_walk
`default_nettype wire

@@ rtl/systematic_particle_resampler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_particle_resampler
// Systematic low-variance resampler over up to PARTICLES Q0.16 weights.
// ----------------------------------------------------------------------------
// Weights load at one request per cycle, while in_stall is low, into one
// bank of a two-bank weight ram. The request flagged is_last closes the
// batch and queues a walk; the next batch loads into the other bank while
// the walk runs. in_stall is high after the is_last request until the walk
// engine takes its command, at once if idle, else when the running walk ends.
// A walk over n loaded weights steps the index at most n-1 times, and each
// step reads one weight through the single registered read port of the
// ram. It emits PARTICLES source indices in slot order, the last one
// flagged by last_slot.
// ----------------------------------------------------------------------------
module systematic_particle_resampler
    import srs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [OFFSET_W-1:0] offset,
    input  wire logic                is_last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [INDEX_W-1:0]  source_index,
    output logic                     last_slot
);

    logic                  q_full;
    logic                  push;
    logic                  pop;
    walk_cmd_t             push_cmd;
    walk_cmd_t             q_head;
    ram_wr_t               ram_wr;
    logic                  rd_en;
    logic [RAM_ADDR_W-1:0] rd_addr;
    logic [WEIGHT_W-1:0]   rd_data;

    srs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .weight   (weight),
        .offset   (offset),
        .is_last  (is_last),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd),
        .ram_wr   (ram_wr)
    );

    srs_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (q_head)
    );

    srs_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srs_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_full       (q_full),
        .q_head       (q_head),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .source_index (source_index),
        .last_slot    (last_slot)
    );

endmodule : systematic_particle_resampler
`default_nettype wire
